>>> hw/rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Shared types and constants for the frame cell chain and the core.
// ----------------------------------------------------------------------------
package fpr_pkg;

   // width of the frame count register
   localparam int CFG_BITS = 5;
   // frame count after reset
   localparam logic [CFG_BITS-1:0] FRAMES_RESET = 5'd3;
   // widths of the fixed result fields
   localparam int FAULT_BITS = 32;
   localparam int FRAME_IDX_BITS = 4;

   // control beat handed from one frame cell to the next
   typedef struct packed {
      logic hit;          // some earlier cell holds the page
      logic evict_valid;  // selected victim frame holds a resident page
   } fpr_chain_type;

endpackage

>>> hw/rtl/fpr_cell.sv
// ----------------------------------------------------------------------------
// FIFO page replacement frame cell
// Holds one frame (page number and valid bit), matches the looked-up page
// and forwards the hit and victim information to the next cell.
// ----------------------------------------------------------------------------
module fpr_cell #(
   parameter int PAGE_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  active,
   input  logic                  sel,
   input  logic                  wr_en,
   input  logic [PAGE_BITS-1:0]  lookup_page,
   input  fpr_pkg::fpr_chain_type chain_in,
   input  logic [PAGE_BITS-1:0]  evict_page_in,
   output fpr_pkg::fpr_chain_type chain_out,
   output logic [PAGE_BITS-1:0]  evict_page_out
);
   import fpr_pkg::*;

   logic                 valid_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 match;

   assign match = active & valid_ff & (page_ff == lookup_page);

   always_comb begin
      chain_out.hit         = chain_in.hit | match;
      chain_out.evict_valid = sel ? valid_ff : chain_in.evict_valid;
      // an empty victim frame reports page zero
      evict_page_out        = (sel & valid_ff) ? page_ff : evict_page_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         page_ff <= lookup_page;
      end
   end

endmodule

>>> hw/rtl/fifo_page_replacement_core.sv
// ----------------------------------------------------------------------------
// FIFO page replacement core
// Looks each page reference up in a chain of frame cells; on a miss loads
// the page into the frame under a round-robin pointer and counts the fault.
// ----------------------------------------------------------------------------
//   channel | direction | beat
//   req_    | in        | page_number
//   rsp_    | out       | hit, fault_count, frame_written, evicted_valid,
//           |           | evicted_page
//   csr_    | in        | frames_in_use (wdata)
//
// One reference per cycle while the result register can take it: the lookup runs
// through the frame cell chain in the accept cycle and the result is registered.
// A new beat is taken while the result register is empty or being drained.
// Synchronous reset empties all frames, clears the pointer and the fault
// count and sets the frame count to three. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_page_replacement_core #(
   parameter int MAX_FRAMES = 16,
   parameter int PAGE_BITS  = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [PAGE_BITS-1:0]                req_page_number,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [fpr_pkg::FAULT_BITS-1:0]      rsp_fault_count,
   output logic [fpr_pkg::FRAME_IDX_BITS-1:0]  rsp_frame_written,
   output logic                                rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]                rsp_evicted_page,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpr_pkg::CFG_BITS-1:0]        csr_wdata
);
   import fpr_pkg::*;

   localparam int PW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int XW = $clog2(MAX_FRAMES + 1) + 1;
   localparam int WW = (XW > CFG_BITS) ? XW : CFG_BITS;

   logic [CFG_BITS-1:0]       frames_ff;
   logic [PW-1:0]             ptr_ff;
   logic [PW-1:0]             ptr_in;
   logic [FAULT_BITS-1:0]     faults_ff;
   logic [FAULT_BITS-1:0]     faults_in;

   logic                      rsp_valid_ff;
   logic                      hit_ff;
   logic [FAULT_BITS-1:0]     fault_count_ff;
   logic [FRAME_IDX_BITS-1:0] frame_written_ff;
   logic                      evicted_valid_ff;
   logic [PAGE_BITS-1:0]      evicted_page_ff;

   logic                      accept;
   logic                      hit;
   logic [XW-1:0]             n_eff;
   logic [PW-1:0]             slot;
   logic [XW-1:0]             slot_next;
   logic [PW+FRAME_IDX_BITS-1:0] slot_wide;

   fpr_chain_type             chain [0:MAX_FRAMES];
   logic [PAGE_BITS-1:0]      evict_page [0:MAX_FRAMES];

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // clamp the frame count to 1..MAX_FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         n_eff = XW'(1);
      end else if (WW'(frames_ff) > WW'(MAX_FRAMES)) begin
         n_eff = XW'(MAX_FRAMES);
      end else begin
         n_eff = XW'(frames_ff);
      end
   end

   // wrap a stale pointer to frame 0 before use
   always_comb begin
      slot      = (XW'(ptr_ff) >= n_eff) ? '0 : ptr_ff;
      slot_next = XW'(slot) + XW'(1);
      ptr_in    = (slot_next >= n_eff) ? '0 : PW'(slot_next);
      slot_wide = {{FRAME_IDX_BITS{1'b0}}, slot};
      faults_in = (faults_ff == '1) ? faults_ff : faults_ff + FAULT_BITS'(1);
   end

   assign chain[0]      = '0;
   assign evict_page[0] = '0;

   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
      logic active;
      logic sel;
      logic wr_en;

      assign active = (XW'(i) < n_eff);
      assign sel    = (slot == PW'(i));
      assign wr_en  = accept & ~hit & sel;

      fpr_cell #(
         .PAGE_BITS (PAGE_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .active         (active),
         .sel            (sel),
         .wr_en          (wr_en),
         .lookup_page    (req_page_number),
         .chain_in       (chain[i]),
         .evict_page_in  (evict_page[i]),
         .chain_out      (chain[i+1]),
         .evict_page_out (evict_page[i+1])
      );
   end

   assign hit = chain[MAX_FRAMES].hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= FRAMES_RESET;
         ptr_ff       <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            frames_ff <= csr_wdata;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // advance the pointer and count the fault on a miss
         if (accept && !hit) begin
            ptr_ff    <= ptr_in;
            faults_ff <= faults_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff <= hit;
         if (hit) begin
            fault_count_ff   <= faults_ff;
            frame_written_ff <= '0;
            evicted_valid_ff <= 1'b0;
            evicted_page_ff  <= '0;
         end else begin
            fault_count_ff   <= faults_in;
            frame_written_ff <= slot_wide[FRAME_IDX_BITS-1:0];
            evicted_valid_ff <= chain[MAX_FRAMES].evict_valid;
            evicted_page_ff  <= evict_page[MAX_FRAMES];
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_fault_count   = fault_count_ff;
   assign rsp_frame_written = frame_written_ff;
   assign rsp_evicted_valid = evicted_valid_ff;
   assign rsp_evicted_page  = evicted_page_ff;

endmodule
